// ----- design/emr_pkg.sv -----
// Shared types, codes and constants of the extent map range lookup block.
package emr_pkg;

  localparam int MaxExtentsDef = 16;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [2:0] STAT_OK      = 3'd0;
  localparam logic [2:0] STAT_OVERLAP = 3'd1;
  localparam logic [2:0] STAT_WRAP    = 3'd2;
  localparam logic [2:0] STAT_FULL    = 3'd3;
  localparam logic [2:0] STAT_EMPTY   = 3'd4;
  localparam logic [2:0] STAT_SKIP    = 3'd5;

  localparam logic [31:0] GAP_TYPE = 32'd3;
  localparam logic [63:0] ADDR_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
    logic [31:0] etype;
  } entry_t;

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
  } piece_t;

  typedef struct packed {
    logic        hit;
    logic        take;
    logic [63:0] span;
    logic [31:0] rem;
  } check_t;

endpackage

// ----- design/emr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module emr_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/emr_piece.sv -----
// Shared piece checker: containment test, span subtract and count compare.
module emr_piece
  import emr_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  piece_t      piece_i,
  input  logic [63:0] off_i,
  input  logic        started_i,
  input  logic [31:0] count_i,
  output check_t      chk_o
);

  logic        hit_q;
  logic [63:0] span_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_q  <= started_i || ((off_i >= piece_i.lo) && (off_i < piece_i.hi));
      span_q <= piece_i.hi - off_i;
    end
  end

  always_comb begin
    chk_o.hit  = hit_q;
    chk_o.span = span_q;
    chk_o.take = (|span_q[63:32]) || (span_q[31:0] >= count_i);
    chk_o.rem  = count_i - span_q[31:0];
  end

endmodule

// ----- design/extent_map_range_lookup.sv -----
// Extent map range lookup: top level with the load, clear and query sequencer.
//
// The block holds up to MaxExtents typed extents in ascending order in a small RAM; gaps
// between them read as type 3. A load or clear passes an accept and an execute state: its
// input is registered on acceptance, and the execute state writes its result to the output
// register once that register is free. A query walks the table from the first entry. Each
// entry takes a read, a gap test and an extent state, and an emit state follows each piece:
// the gap, when one precedes the extent, and the extent. The trailing gap then takes a read,
// a tail and an emit state, and a start that lies in no piece adds a miss state. A query ends
// once the count is covered and waits while the output register is not free. A single shared
// piece checker does every containment test and span subtraction. One item is in work at a
// time; the next one is taken while the final result still waits in the output register.
module extent_map_range_lookup
  import emr_pkg::*;
#(
  parameter int MaxExtents = MaxExtentsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [63:0] offset_i,
  input  logic [63:0] length_i,
  input  logic [31:0] extent_type_i,
  input  logic [31:0] query_count_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] out_offset_o,
  output logic [63:0] out_length_o,
  output logic [31:0] out_type_o,
  output logic [2:0]  status_o,
  output logic        last_o
);

  localparam int IdxW = (MaxExtents > 1) ? $clog2(MaxExtents) : 1;
  localparam int CntW = $clog2(MaxExtents + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_GAP,
    S_EXT,
    S_TAIL,
    S_EMIT,
    S_MISS
  } state_e;

  state_e state_q, state_d, ret_q, ret_d;

  logic [1:0]      kind_q, kind_d;
  logic [63:0]     off_q, off_d;
  logic [63:0]     len_q, len_d;
  logic [31:0]     type_q, type_d;
  logic [31:0]     qcnt_q, qcnt_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [63:0]     cov_q, cov_d;
  logic [63:0]     pos_q, pos_d;
  logic            started_q, started_d;
  logic [63:0]     pe_q, pe_d;
  logic [31:0]     pt_q, pt_d;
  logic            pfin_q, pfin_d;

  logic        ovalid_q, ovalid_d;
  logic [63:0] ooff_q, ooff_d;
  logic [63:0] olen_q, olen_d;
  logic [31:0] otype_q, otype_d;
  logic [2:0]  ostat_q, ostat_d;
  logic        olast_q, olast_d;

  logic        ram_we, ram_re;
  entry_t      ram_wdata, ram_rdata;
  logic        unit_en;
  piece_t      piece;
  check_t      chk;
  logic        ofree;
  logic        emit_last;
  logic [64:0] lsum;

  emr_ram #(
    .Width($bits(entry_t)),
    .Depth(MaxExtents)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(cnt_q[IdxW-1:0]),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(idx_q[IdxW-1:0]),
    .rdata_o(ram_rdata)
  );

  emr_piece u_piece (
    .clk_i    (clk_i),
    .en_i     (unit_en),
    .piece_i  (piece),
    .off_i    (off_q),
    .started_i(started_q),
    .count_i  (qcnt_q),
    .chk_o    (chk)
  );

  assign ofree     = !ovalid_q || out_ready_i;
  assign lsum      = {1'b0, off_q} + {1'b0, len_q};
  assign emit_last = chk.take || pfin_q;

  assign ram_wdata.lo    = off_q;
  assign ram_wdata.hi    = lsum[63:0];
  assign ram_wdata.etype = type_q;

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    kind_d    = kind_q;
    off_d     = off_q;
    len_d     = len_q;
    type_d    = type_q;
    qcnt_d    = qcnt_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    cov_d     = cov_q;
    pos_d     = pos_q;
    started_d = started_q;
    pe_d      = pe_q;
    pt_d      = pt_q;
    pfin_d    = pfin_q;
    ovalid_d  = ovalid_q && !out_ready_i;
    ooff_d    = ooff_q;
    olen_d    = olen_q;
    otype_d   = otype_q;
    ostat_d   = ostat_q;
    olast_d   = olast_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    unit_en   = 1'b0;
    piece     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d  = kind_i;
          off_d   = offset_i;
          len_d   = length_i;
          type_d  = extent_type_i;
          qcnt_d  = query_count_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (kind_q)
          KIND_LOAD: begin
            if (ofree) begin
              ovalid_d = 1'b1;
              ooff_d   = '0;
              olen_d   = '0;
              otype_d  = '0;
              olast_d  = 1'b1;
              priority if (len_q == '0) begin
                ostat_d = STAT_SKIP;
              end else if (off_q < cov_q) begin
                ostat_d = STAT_OVERLAP;
              end else if (lsum[64]) begin
                ostat_d = STAT_WRAP;
              end else if (cnt_q >= CntW'(MaxExtents)) begin
                ostat_d = STAT_FULL;
              end else begin
                ostat_d = STAT_OK;
                ram_we  = 1'b1;
                cnt_d   = cnt_q + CntW'(1);
                cov_d   = lsum[63:0];
              end
              state_d = S_IDLE;
            end
          end
          KIND_QUERY: begin
            if (qcnt_q == '0) begin
              if (ofree) begin
                ovalid_d = 1'b1;
                ooff_d   = '0;
                olen_d   = '0;
                otype_d  = '0;
                ostat_d  = STAT_EMPTY;
                olast_d  = 1'b1;
                state_d  = S_IDLE;
              end
            end else begin
              pos_d     = '0;
              idx_d     = '0;
              started_d = 1'b0;
              state_d   = S_READ;
            end
          end
          KIND_CLEAR: begin
            if (ofree) begin
              cnt_d    = '0;
              cov_d    = '0;
              ovalid_d = 1'b1;
              ooff_d   = '0;
              olen_d   = '0;
              otype_d  = '0;
              ostat_d  = STAT_OK;
              olast_d  = 1'b1;
              state_d  = S_IDLE;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_READ: begin
        if (idx_q < cnt_q) begin
          ram_re  = 1'b1;
          state_d = S_GAP;
        end else begin
          state_d = S_TAIL;
        end
      end
      S_GAP: begin
        if (ram_rdata.lo > pos_q) begin
          piece.lo = pos_q;
          piece.hi = ram_rdata.lo;
          unit_en  = 1'b1;
          pe_d     = ram_rdata.lo;
          pt_d     = GAP_TYPE;
          pfin_d   = 1'b0;
          ret_d    = S_EXT;
          state_d  = S_EMIT;
        end else begin
          state_d = S_EXT;
        end
      end
      S_EXT: begin
        piece.lo = ram_rdata.lo;
        piece.hi = ram_rdata.hi;
        unit_en  = 1'b1;
        pe_d     = ram_rdata.hi;
        pt_d     = ram_rdata.etype;
        pfin_d   = ((idx_q + CntW'(1)) == cnt_q) && (ram_rdata.hi == ADDR_MAX);
        pos_d    = ram_rdata.hi;
        idx_d    = idx_q + CntW'(1);
        ret_d    = S_READ;
        state_d  = S_EMIT;
      end
      S_TAIL: begin
        if (pos_q != ADDR_MAX) begin
          piece.lo = pos_q;
          piece.hi = ADDR_MAX;
          unit_en  = 1'b1;
          pe_d     = ADDR_MAX;
          pt_d     = GAP_TYPE;
          pfin_d   = 1'b1;
          ret_d    = S_MISS;
          state_d  = S_EMIT;
        end else begin
          state_d = S_MISS;
        end
      end
      S_EMIT: begin
        if (!chk.hit) begin
          state_d = ret_q;
        end else if (ofree) begin
          ovalid_d  = 1'b1;
          ooff_d    = off_q;
          olen_d    = chk.span;
          otype_d   = pt_q;
          ostat_d   = STAT_OK;
          olast_d   = emit_last;
          off_d     = pe_q;
          started_d = 1'b1;
          qcnt_d    = chk.take ? '0 : chk.rem;
          state_d   = emit_last ? S_IDLE : ret_q;
        end
      end
      S_MISS: begin
        if (ofree) begin
          ovalid_d = 1'b1;
          ooff_d   = off_q;
          olen_d   = '0;
          otype_d  = GAP_TYPE;
          ostat_d  = STAT_OK;
          olast_d  = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ret_q     <= S_IDLE;
      kind_q    <= '0;
      off_q     <= '0;
      len_q     <= '0;
      type_q    <= '0;
      qcnt_q    <= '0;
      cnt_q     <= '0;
      idx_q     <= '0;
      cov_q     <= '0;
      pos_q     <= '0;
      started_q <= 1'b0;
      pe_q      <= '0;
      pt_q      <= '0;
      pfin_q    <= 1'b0;
      ovalid_q  <= 1'b0;
      ooff_q    <= '0;
      olen_q    <= '0;
      otype_q   <= '0;
      ostat_q   <= '0;
      olast_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      ret_q     <= ret_d;
      kind_q    <= kind_d;
      off_q     <= off_d;
      len_q     <= len_d;
      type_q    <= type_d;
      qcnt_q    <= qcnt_d;
      cnt_q     <= cnt_d;
      idx_q     <= idx_d;
      cov_q     <= cov_d;
      pos_q     <= pos_d;
      started_q <= started_d;
      pe_q      <= pe_d;
      pt_q      <= pt_d;
      pfin_q    <= pfin_d;
      ovalid_q  <= ovalid_d;
      ooff_q    <= ooff_d;
      olen_q    <= olen_d;
      otype_q   <= otype_d;
      ostat_q   <= ostat_d;
      olast_q   <= olast_d;
    end
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = ovalid_q;
  assign out_offset_o = ooff_q;
  assign out_length_o = olen_q;
  assign out_type_o   = otype_q;
  assign status_o     = ostat_q;
  assign last_o       = olast_q;

endmodule

// ----- tb/sv/extent_map_range_lookup_tb.sv -----
// Self-checking testbench for the extent map range lookup block: directed table, then random.
module extent_map_range_lookup_tb;
  import emr_pkg::*;

  localparam int          MAX_EXT    = MaxExtentsDef;
  localparam int          MAX_PIECES = 2 * MAX_EXT + 1;
  localparam logic [1:0]  KIND_NONE  = 2'd3;
  localparam int          ITEMS      = 330;
  localparam int          HOLD_CYCLES = 300;

  typedef struct {
    logic [1:0]  kind;
    logic [63:0] off;
    logic [63:0] len;
    logic [31:0] etype;
    logic [31:0] cnt;
  } req_t;

  typedef struct {
    logic [63:0] off;
    logic [63:0] len;
    logic [31:0] typ;
    logic [2:0]  st;
    logic        last;
  } piece_res_t;

  typedef struct {
    req_t       rq;
    bit         typed;
    piece_res_t want;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  kind_i = '0;
  logic [63:0] offset_i = '0;
  logic [63:0] length_i = '0;
  logic [31:0] extent_type_i = '0;
  logic [31:0] query_count_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] out_offset_o;
  logic [63:0] out_length_o;
  logic [31:0] out_type_o;
  logic [2:0]  status_o;
  logic        last_o;

  logic [63:0] map_lo   [MAX_EXT];
  logic [63:0] map_len  [MAX_EXT];
  logic [31:0] map_type [MAX_EXT];
  int          map_fill = 0;
  logic [63:0] map_end  = '0;

  piece_res_t  fresh[$];
  piece_res_t  expected_pieces[$];
  dir_row_t    dir_rows[$];
  int          mismatches = 0;
  int          accepted_reqs = 0;
  int          counted_reqs = 0;
  bit          quiet_phase = 1'b0;
  bit          hold_out = 1'b0;

  extent_map_range_lookup u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .offset_i     (offset_i),
    .length_i     (length_i),
    .extent_type_i(extent_type_i),
    .query_count_i(query_count_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_offset_o (out_offset_o),
    .out_length_o (out_length_o),
    .out_type_o   (out_type_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic piece_res_t mk_piece(logic [63:0] off, logic [63:0] len, logic [31:0] typ,
                                          logic [2:0] st, logic last);
    piece_res_t p;
    p.off = off;
    p.len = len;
    p.typ = typ;
    p.st = st;
    p.last = last;
    return p;
  endfunction

  function automatic void predict_request(req_t r);
    logic [63:0] pc_lo [MAX_PIECES];
    logic [63:0] pc_hi [MAX_PIECES];
    logic [31:0] pc_ty [MAX_PIECES];
    logic [63:0] pos;
    logic [63:0] e;
    logic [63:0] off;
    logic [63:0] span;
    logic [31:0] cnt;
    logic [2:0]  st;
    int          n;
    int          i;
    int          hit;
    fresh.delete();
    case (r.kind)
      KIND_LOAD: begin
        e = r.off + r.len;
        if (r.len == 64'd0) st = STAT_SKIP;
        else if (r.off < map_end) st = STAT_OVERLAP;
        else if (e < r.off) st = STAT_WRAP;
        else if (map_fill >= MAX_EXT) st = STAT_FULL;
        else begin
          map_lo[map_fill] = r.off;
          map_len[map_fill] = r.len;
          map_type[map_fill] = r.etype;
          map_fill++;
          map_end = e;
          st = STAT_OK;
        end
        fresh.push_back(mk_piece('0, '0, '0, st, 1'b1));
      end
      KIND_CLEAR: begin
        map_fill = 0;
        map_end = '0;
        fresh.push_back(mk_piece('0, '0, '0, STAT_OK, 1'b1));
      end
      KIND_QUERY: begin
        if (r.cnt == 32'd0) begin
          fresh.push_back(mk_piece('0, '0, '0, STAT_EMPTY, 1'b1));
        end else begin
          n = 0;
          pos = '0;
          for (i = 0; i < map_fill; i++) begin
            e = map_lo[i] + map_len[i];
            if (map_lo[i] > pos) begin
              pc_lo[n] = pos;
              pc_hi[n] = map_lo[i];
              pc_ty[n] = GAP_TYPE;
              n++;
            end
            pc_lo[n] = map_lo[i];
            pc_hi[n] = e;
            pc_ty[n] = map_type[i];
            n++;
            pos = e;
          end
          if (pos < ADDR_MAX) begin
            pc_lo[n] = pos;
            pc_hi[n] = ADDR_MAX;
            pc_ty[n] = GAP_TYPE;
            n++;
          end
          hit = n;
          for (i = 0; i < n; i++) begin
            if (hit == n && r.off >= pc_lo[i] && r.off < pc_hi[i]) hit = i;
          end
          if (hit >= n) begin
            fresh.push_back(mk_piece(r.off, '0, GAP_TYPE, STAT_OK, 1'b1));
          end else begin
            i = hit;
            off = r.off;
            cnt = r.cnt;
            while (cnt != 32'd0 && i < n) begin
              span = pc_hi[i] - off;
              if (span >= {32'd0, cnt}) cnt = 32'd0;
              else cnt = cnt - span[31:0];
              fresh.push_back(mk_piece(off, span, pc_ty[i], STAT_OK,
                                       (cnt == 32'd0) || (i + 1 >= n)));
              off = pc_hi[i];
              i++;
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    $display("MISMATCH t=%0t %s", $time, what);
  endtask

  task automatic check_piece();
    piece_res_t w;
    if (expected_pieces.size() == 0) begin
      report_mismatch($sformatf("unexpected result off=%h len=%h", out_offset_o, out_length_o));
    end else begin
      w = expected_pieces.pop_front();
      if (out_offset_o !== w.off)
        report_mismatch($sformatf("out_offset %h, want %h", out_offset_o, w.off));
      if (out_length_o !== w.len)
        report_mismatch($sformatf("out_length %h, want %h", out_length_o, w.len));
      if (out_type_o !== w.typ)
        report_mismatch($sformatf("out_type %h, want %h", out_type_o, w.typ));
      if (status_o !== w.st)
        report_mismatch($sformatf("status %0d, want %0d", status_o, w.st));
      if (last_o !== w.last)
        report_mismatch($sformatf("last %0b, want %0b", last_o, w.last));
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 31);
    if (quiet_phase || r < 20) return 0;
    if (r < 29) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_request(req_t rq, bit typed, piece_res_t want);
    int gap;
    in_valid_i <= 1'b1;
    kind_i <= rq.kind;
    offset_i <= rq.off;
    length_i <= rq.len;
    extent_type_i <= rq.etype;
    query_count_i <= rq.cnt;
    do @(posedge clk_i); while (!in_ready_o);
    predict_request(rq);
    if (typed) expected_pieces.push_back(want);
    else foreach (fresh[k]) expected_pieces.push_back(fresh[k]);
    accepted_reqs++;
    if (rq.kind != KIND_NONE) counted_reqs++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic add_row(logic [1:0] kind, logic [63:0] off, logic [63:0] len,
                         logic [31:0] etype, logic [31:0] cnt, bit typed,
                         logic [63:0] w_off, logic [63:0] w_len, logic [31:0] w_typ,
                         logic [2:0] w_st);
    dir_row_t row;
    row.rq.kind = kind;
    row.rq.off = off;
    row.rq.len = len;
    row.rq.etype = etype;
    row.rq.cnt = cnt;
    row.typed = typed;
    row.want = mk_piece(w_off, w_len, w_typ, w_st, 1'b1);
    dir_rows.push_back(row);
  endtask

  task automatic random_phase();
    logic [63:0] base;
    logic [63:0] pos;
    logic [63:0] d;
    logic [63:0] reach;
    int          nload;
    int          nq;
    int          sel;
    bit          fill_mode;
    req_t        rq;
    piece_res_t  none;
    none = mk_piece('0, '0, '0, STAT_OK, 1'b0);
    quiet_phase <= ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 3))
      0: base = '0;
      1: base = {$urandom, $urandom};
      2: base = ADDR_MAX - 64'($urandom_range(0, 4000));
      default: base = 64'($urandom_range(0, 1000));
    endcase
    if ($urandom_range(0, 7) != 0) begin
      rq = '{KIND_CLEAR, {$urandom, $urandom}, {$urandom, $urandom}, $urandom, $urandom};
      send_request(rq, 1'b0, none);
    end
    pos = (base > map_end) ? base : map_end;
    fill_mode = ($urandom_range(0, 3) == 0);
    nload = fill_mode ? $urandom_range(16, 20) : $urandom_range(0, 18);
    for (int k = 0; k < nload; k++) begin
      rq.kind = KIND_LOAD;
      rq.etype = $urandom;
      rq.cnt = $urandom;
      sel = fill_mode ? 31 : $urandom_range(0, 31);
      case (sel)
        0: begin
          rq.off = pos;
          rq.len = '0;
        end
        1: begin
          rq.off = pos - 64'($urandom_range(1, 8));
          rq.len = 64'($urandom_range(1, 64));
        end
        2: begin
          d = 64'($urandom_range(0, 100));
          rq.off = ADDR_MAX - d;
          rq.len = d + 64'd1 + 64'($urandom_range(0, 1000));
        end
        default: begin
          rq.off = pos + (($urandom_range(0, 3) == 0) ? 64'd0 : 64'($urandom_range(1, 64)));
          if ($urandom_range(0, 7) == 0) rq.len = {$urandom, $urandom} >> $urandom_range(1, 40);
          else rq.len = 64'($urandom_range(1, 64));
        end
      endcase
      send_request(rq, 1'b0, none);
      pos = (pos > map_end) ? pos : map_end;
    end
    reach = (map_end > base) ? map_end - base : 64'd0;
    if (reach > 64'd100000) reach = 64'd100000;
    nq = $urandom_range(1, 8);
    for (int k = 0; k < nq; k++) begin
      rq.kind = KIND_QUERY;
      rq.len = {$urandom, $urandom};
      rq.etype = $urandom;
      case ($urandom_range(0, 15))
        0: rq.off = {$urandom, $urandom};
        1: rq.off = ADDR_MAX;
        default: rq.off = base - 64'($urandom_range(0, 16)) +
                          64'($urandom_range(0, int'(reach[31:0])));
      endcase
      case ($urandom_range(0, 15))
        0: rq.cnt = '0;
        1, 2: rq.cnt = $urandom;
        default: rq.cnt = $urandom_range(1, int'(reach[31:0]) + 64);
      endcase
      send_request(rq, 1'b0, none);
    end
    repeat ($urandom_range(0, 2)) begin
      rq = '{2'($urandom_range(0, 3)), {$urandom, $urandom}, {$urandom, $urandom},
             $urandom, $urandom};
      send_request(rq, 1'b0, none);
    end
  endtask

  initial begin
    add_row(KIND_QUERY, 64'd0, 64'd0, 32'd0, 32'd1, 1'b1, 64'd0, ADDR_MAX, GAP_TYPE, STAT_OK);
    add_row(KIND_QUERY, 64'h40, 64'd0, 32'd0, 32'd0, 1'b1, 64'd0, 64'd0, 32'd0, STAT_EMPTY);
    add_row(KIND_QUERY, ADDR_MAX, 64'd0, 32'd0, 32'd5, 1'b1, ADDR_MAX, 64'd0, GAP_TYPE,
            STAT_OK);
    add_row(KIND_LOAD, 64'h80, 64'd0, 32'd1, 32'd0, 1'b1, 64'd0, 64'd0, 32'd0, STAT_SKIP);
    add_row(KIND_LOAD, 64'h100, 64'h10, 32'd0, 32'd0, 1'b1, 64'd0, 64'd0, 32'd0, STAT_OK);
    add_row(KIND_LOAD, 64'h108, 64'h4, 32'd1, 32'd0, 1'b1, 64'd0, 64'd0, 32'd0, STAT_OVERLAP);
    add_row(KIND_LOAD, ADDR_MAX, 64'd2, 32'd1, 32'd0, 1'b1, 64'd0, 64'd0, 32'd0, STAT_WRAP);
    add_row(KIND_LOAD, 64'h200, 64'h20, 32'd1, 32'd0, 1'b1, 64'd0, 64'd0, 32'd0, STAT_OK);
    add_row(KIND_LOAD, 64'h220, 64'h10, 32'd2, 32'd0, 1'b1, 64'd0, 64'd0, 32'd0, STAT_OK);
    add_row(KIND_QUERY, 64'd0, 64'd0, 32'd0, 32'h300, 1'b0, '0, '0, '0, STAT_OK);
    add_row(KIND_QUERY, 64'h104, 64'd0, 32'd0, 32'd1, 1'b0, '0, '0, '0, STAT_OK);
    add_row(KIND_QUERY, 64'h1f0, 64'd0, 32'd0, 32'h30, 1'b0, '0, '0, '0, STAT_OK);
    add_row(KIND_QUERY, 64'h230, 64'd0, 32'd0, 32'hFFFF_FFFF, 1'b0, '0, '0, '0, STAT_OK);
    add_row(KIND_LOAD, ADDR_MAX - 64'h10, 64'h10, 32'hFFFF_FFFF, 32'd0, 1'b1, 64'd0, 64'd0,
            32'd0, STAT_OK);
    add_row(KIND_QUERY, ADDR_MAX - 64'h8, 64'd0, 32'd0, 32'hFFFF_FFFF, 1'b0, '0, '0, '0,
            STAT_OK);
    add_row(KIND_QUERY, ADDR_MAX, 64'd0, 32'd0, 32'd1, 1'b1, ADDR_MAX, 64'd0, GAP_TYPE,
            STAT_OK);
    add_row(KIND_NONE, ADDR_MAX, ADDR_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0, '0, '0,
            STAT_OK);
    add_row(KIND_CLEAR, 64'd0, 64'd0, 32'd0, 32'd0, 1'b1, 64'd0, 64'd0, 32'd0, STAT_OK);
    add_row(KIND_LOAD, 64'd0, ADDR_MAX, 32'd3, 32'd0, 1'b1, 64'd0, 64'd0, 32'd0, STAT_OK);
    add_row(KIND_QUERY, 64'd0, 64'd0, 32'd0, 32'hFFFF_FFFF, 1'b0, '0, '0, '0, STAT_OK);
    add_row(KIND_LOAD, ADDR_MAX, 64'd1, 32'd0, 32'd0, 1'b1, 64'd0, 64'd0, 32'd0, STAT_WRAP);
    add_row(KIND_CLEAR, 64'd0, 64'd0, 32'd0, 32'd0, 1'b1, 64'd0, 64'd0, 32'd0, STAT_OK);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[k]) send_request(dir_rows[k].rq, dir_rows[k].typed, dir_rows[k].want);
    while (counted_reqs < ITEMS) random_phase();
    in_valid_i <= 1'b0;
    while (expected_pieces.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    int stall_left;
    stall_left = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) check_piece();
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (hold_out) begin
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (!quiet_phase && $urandom_range(0, 7) == 0)
          stall_left = ($urandom_range(0, 31) < 29) ? $urandom_range(1, 3) : $urandom_range(15, 40);
      end
    end
  end

  initial begin
    wait (accepted_reqs >= 100);
    @(posedge clk_i);
    hold_out <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_out <= 1'b0;
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
